FILE: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

FILE: sv/pcgr_pkg.sv
// package: types, constants and helpers of the pcg32 generator
package pcgr_pkg;
  localparam logic [63:0] LcgMult = 64'd6364136223846793005;
  localparam int unsigned QueueDepth = 2;
  localparam logic [1:0] OpRaw = 2'd0;
  localparam logic [1:0] OpBound = 2'd1;
  localparam logic [1:0] OpRange = 2'd2;
  localparam logic [1:0] OpSeed = 2'd3;

  typedef enum logic [1:0] {
    CMD_DRAW,
    CMD_BOUND,
    CMD_SEED,
    CMD_ERROR
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] limit;
    logic [31:0] offset;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR,
    ST_DRAW,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ADD,
    ST_CHECK,
    ST_MOD,
    ST_SEED_ADD,
    ST_OUT
  } state_e;

  function automatic logic [31:0] pcg_out(input logic [63:0] old);
    logic [31:0] mixed;
    logic [4:0]  rot;
    mixed = 32'(((old >> 18) ^ old) >> 27);
    rot   = old[63:59];
    return (mixed >> rot) | (mixed << ((5'd0 - rot) & 5'd31));
  endfunction
endpackage

FILE: sv/pcgr_if.sv
// valid/ready channel interface
interface pcgr_if #(
  parameter int unsigned W = 32
) (
  input logic clk_i
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/pcgr_front.sv
// front end: decodes requests into commands and queues them
`include "assert_macros.svh"
module pcgr_front
  import pcgr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] bound_i,
  input  logic [31:0] min_value_i,
  input  logic [31:0] max_value_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  cmd_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  cmd_t dec;
  logic push, pop;

  always_comb begin
    dec.cmd    = CMD_DRAW;
    dec.limit  = 32'd0;
    dec.offset = 32'd0;
    unique case (operation_i)
      OpRaw: dec.cmd = CMD_DRAW;
      OpBound: begin
        dec.cmd   = (bound_i == 32'd0) ? CMD_DRAW : CMD_BOUND;
        dec.limit = bound_i;
      end
      OpRange: begin
        dec.offset = min_value_i;
        dec.limit  = max_value_i - min_value_i + 32'd1;
        if ($signed(max_value_i) < $signed(min_value_i)) dec.cmd = CMD_ERROR;
        else if (dec.limit == 32'd0) dec.cmd = CMD_DRAW;
        else dec.cmd = CMD_BOUND;
      end
      default: dec.cmd = CMD_SEED;
    endcase
  end

  assign in_ready_o  = (cnt_q != (AW+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_q <= (AW+1)'(Depth), "queue overfilled")
  `ASSERT_CLK(a_cnt_step, push && !pop |=> cnt_q == $past(cnt_q) + 1'b1, "bad count")
  `ASSERT_NEVER(a_pop_empty, pop && cnt_q == '0, "pop from empty queue")
endmodule

FILE: sv/pcgr_back.sv
// back end: lcg, rejection loop and serial modulo
`include "assert_macros.svh"
module pcgr_back
  import pcgr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] seed_value_i,
  input  logic [63:0] stream_select_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o,
  output logic        range_error_o
);
  state_e st_q, st_d;
  cmd_t cmd_q;
  logic [63:0] state_q, inc_q, acc_q, old_q;
  logic [31:0] thr_q, word_q, res_q;
  logic [32:0] rem_q;
  logic [5:0] cnt_q;
  logic err_q, seed_q, seed2_q, boot_q;
  logic [63:0] pp;
  logic [31:0] dividend;
  logic [32:0] trial;
  logic [31:0] word_n;

  always_comb begin
    unique case (st_q)
      ST_MUL0: pp = 64'(state_q[31:0]) * 64'(LcgMult[31:0]);
      ST_MUL1: pp = {state_q[31:0] * LcgMult[63:32], 32'd0};
      default: pp = {state_q[63:32] * LcgMult[31:0], 32'd0};
    endcase
  end

  assign dividend = thr_q;
  assign trial = {rem_q[31:0], dividend[31]} - {1'b0, cmd_q.limit};
  assign word_n = pcg_out(old_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (boot_q) st_d = ST_MUL0;
               else if (cmd_valid_i) st_d = ST_DRAW;
      ST_DRAW: begin
        if (cmd_q.cmd == CMD_ERROR) st_d = ST_OUT;
        else if (cmd_q.cmd == CMD_BOUND) st_d = ST_THR;
        else st_d = ST_MUL0;
      end
      ST_MUL0: st_d = ST_MUL1;
      ST_MUL1: st_d = ST_MUL2;
      ST_MUL2: st_d = ST_ADD;
      ST_ADD: st_d = ST_CHECK;
      ST_THR: st_d = (cnt_q == 6'd32) ? ST_MUL0 : ST_THR;
      ST_CHECK: begin
        if (seed_q || seed2_q) st_d = seed_q ? ST_SEED_ADD : (boot_q ? ST_IDLE : ST_OUT);
        else if (cmd_q.cmd == CMD_BOUND) st_d = ST_MOD;
        else st_d = ST_OUT;
      end
      ST_SEED_ADD: st_d = ST_MUL0;
      ST_MOD: begin
        if (cnt_q == 6'd0 && word_q < res_q) st_d = ST_MUL0;
        else if (cnt_q == 6'd32) st_d = ST_OUT;
      end
      ST_OUT: if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign cmd_ready_o   = (st_q == ST_IDLE) && !boot_q;
  assign out_valid_o   = (st_q == ST_OUT);
  assign value_o       = res_q;
  assign range_error_o = err_q;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: if (cmd_valid_i && !boot_q) cmd_q <= cmd_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      state_q <= '0;
      inc_q   <= 64'd1;
      acc_q   <= '0;
      old_q   <= '0;
      thr_q   <= '0;
      word_q  <= '0;
      res_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      seed_q  <= 1'b1;
      seed2_q <= 1'b0;
      boot_q  <= 1'b1;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_IDLE: if (!boot_q && cmd_valid_i) begin
          err_q <= 1'b0;
          res_q <= '0;
          cnt_q <= '0;
          if (cmd_i.cmd == CMD_SEED) begin
            state_q <= '0;
            inc_q   <= {stream_select_i[62:0], 1'b1};
            seed_q  <= 1'b1;
          end
        end
        ST_DRAW: begin
          if (cmd_q.cmd == CMD_ERROR) begin
            err_q <= 1'b1;
          end else if (cmd_q.cmd == CMD_BOUND) begin
            thr_q <= 32'd0 - cmd_q.limit;
            rem_q <= '0;
            cnt_q <= '0;
          end
        end
        ST_THR: begin
          if (cnt_q == 6'd32) begin
            res_q <= rem_q[31:0];
            cnt_q <= '0;
          end else begin
            rem_q <= trial[32] ? {rem_q[31:0], dividend[31]} : trial;
            thr_q <= {thr_q[30:0], 1'b0};
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_MUL0: begin
          old_q <= state_q;
          acc_q <= pp + inc_q;
        end
        ST_MUL1: acc_q <= acc_q + pp;
        ST_MUL2: acc_q <= acc_q + pp;
        ST_ADD: begin
          state_q <= acc_q;
          word_q  <= word_n;
        end
        ST_CHECK: begin
          if (seed_q) begin
            seed_q  <= 1'b0;
            seed2_q <= 1'b1;
          end else if (seed2_q) begin
            seed2_q <= 1'b0;
            boot_q  <= 1'b0;
          end else if (cmd_q.cmd == CMD_DRAW) begin
            res_q <= word_q + cmd_q.offset;
          end else begin
            thr_q <= word_q;
            rem_q <= '0;
            cnt_q <= '0;
          end
        end
        ST_SEED_ADD: state_q <= state_q + seed_value_i;
        ST_MOD: begin
          if (cnt_q == 6'd32) begin
            res_q <= rem_q[31:0] + cmd_q.offset;
          end else begin
            rem_q <= trial[32] ? {rem_q[31:0], dividend[31]} : trial;
            thr_q <= {thr_q[30:0], 1'b0};
            cnt_q <= cnt_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_q),
    "result changed while stalled")
  `ASSERT_NEVER(a_err_val, out_valid_o && err_q && res_q != '0, "error with nonzero value")
  `ASSERT_NEVER(a_boot_out, boot_q && out_valid_o, "result during seeding")
endmodule

FILE: sv/pcg32_bounded_random.sv
// top level of the pcg32 bounded random generator
// usage:
//   req channel carries operation, bound, min_value, max_value; rsp carries
//   value and range_error, one response word per request word.
//   both channels use valid/ready; a word moves when both are high.
//   an apb port holds seed_value (0x0) and stream_select (0x8); writes take
//   effect only on the next reseed request.
// processing:
//   a raw draw runs one lcg step once its request word is taken; the lcg
//   step is a 64-bit multiply split into three 32x32 partial products.
//   a bounded draw adds a bit-serial threshold remainder and a bit-serial
//   modulo, and repeats the lcg step on each rejected draw.
//   a reseed takes two lcg steps.
//   one request at a time; the next is taken in idle, after the response goes.
// reset:
//   the generator seeds itself from zero registers and
//   accepts commands into a two-entry queue meanwhile.
// stalls:
//   the result waits in its register until taken; the queue keeps accepting
//   requests until full.
module pcg32_bounded_random
  import pcgr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  pcgr_if.sink        req,
  pcgr_if.source      rsp
);
  logic [63:0] seed_q, stream_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic [31:0] value;
  logic range_error;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? stream_q : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      stream_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == 4'd0) seed_q <= pwdata;
      else if (paddr == 4'd8) stream_q <= pwdata;
    end
  end

  pcgr_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .operation_i(req.data[1:0]), .bound_i(req.data[33:2]),
    .min_value_i(req.data[65:34]), .max_value_i(req.data[97:66]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  pcgr_back u_back (
    .clk_i, .rst_ni,
    .seed_value_i(seed_q), .stream_select_i(stream_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .value_o(value), .range_error_o(range_error)
  );

  assign rsp.data = {range_error, value};
endmodule

FILE: verif/testbench.sv
// testbench for the pcg32 bounded random generator: random and directed requests against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcgr_pkg::*;

  localparam int unsigned ReqW = 98;
  localparam int unsigned RspW = 33;
  localparam int unsigned CycleLimit = 3000000;
  localparam logic [3:0] AddrSeed = 4'h0;
  localparam logic [3:0] AddrStream = 4'h8;

  class pcg_scoreboard;
    bit [63:0] seed_reg, stream_reg, lcg_state, lcg_inc;
    bit [32:0] expected_words[$];

    function void init();
      seed_reg = '0;
      stream_reg = '0;
      expected_words.delete();
      reseed();
    endfunction

    function bit [31:0] next_word();
      bit [63:0] old;
      bit [31:0] mixed;
      bit [63:0] both;
      old = lcg_state;
      lcg_state = old * LcgMult + lcg_inc;
      mixed = 32'(((old >> 18) ^ old) >> 27);
      both = {mixed, mixed} >> old[63:59];
      return both[31:0];
    endfunction

    function void reseed();
      lcg_state = '0;
      lcg_inc = {stream_reg[62:0], 1'b1};
      void'(next_word());
      lcg_state += seed_reg;
      void'(next_word());
    endfunction

    function bit [31:0] draw_below(bit [31:0] lim);
      bit [31:0] thr, r;
      if (lim == 0) return next_word();
      thr = (32'd0 - lim) % lim;
      do r = next_word(); while (r < thr);
      return r % lim;
    endfunction

    function void note_request(logic [1:0] op, bit [31:0] bound, bit [31:0] lo, bit [31:0] hi);
      bit [31:0] v;
      bit err;
      v = '0;
      err = 1'b0;
      case (op)
        OpRaw: v = next_word();
        OpBound: v = draw_below(bound);
        OpRange: begin
          if ($signed(hi) < $signed(lo)) err = 1'b1;
          else v = draw_below(hi - lo + 32'd1) + lo;
        end
        default: reseed();
      endcase
      expected_words.push_back({err, v});
    endfunction

    function string check_result(bit [32:0] got);
      bit [32:0] want;
      if (expected_words.size() == 0) return $sformatf("unexpected word %h", got);
      want = expected_words.pop_front();
      if (got[31:0] != want[31:0])
        return $sformatf("value %h, expected %h", got[31:0], want[31:0]);
      if (got[32] != want[32])
        return $sformatf("range_error %b, expected %b", got[32], want[32]);
      return "";
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  pcgr_if #(.W(ReqW)) req_if (clk_i);
  pcgr_if #(.W(RspW)) rsp_if (clk_i);

  pcg32_bounded_random i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req(req_if.sink), .rsp(rsp_if.source)
  );

  pcg_scoreboard sb = new();
  int unsigned fails = 0, cycles = 0, words_checked = 0;
  int unsigned op_count[4] = '{0, 0, 0, 0};
  int unsigned range_errors = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic report(input string msg);
    fails++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] wdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_registers(input logic [63:0] seed, input logic [63:0] stream);
    apb_write(AddrSeed, seed);
    apb_write(AddrStream, stream);
    sb.seed_reg = seed;
    sb.stream_reg = stream;
  endtask

  task automatic wait_drained();
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_request(input logic [1:0] op, input logic [31:0] bound,
                              input logic [31:0] lo, input logic [31:0] hi);
    int unsigned gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= {hi, lo, bound, op};
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
    sb.note_request(op, bound, lo, hi);
    op_count[op]++;
    if (op == OpRange && $signed(hi) < $signed(lo)) range_errors++;
  endtask

  task automatic end_burst();
    req_if.valid <= 1'b0;
  endtask

  task automatic random_request();
    logic [1:0] op;
    logic [31:0] bound, lo, hi;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    op = pick < 25 ? OpRaw : pick < 60 ? OpBound : pick < 95 ? OpRange : OpSeed;
    case ($urandom_range(0, 4))
      0: bound = $urandom_range(1, 16);
      1: bound = 32'd1 << $urandom_range(0, 31);
      2: bound = $urandom_range(0, 1000);
      default: bound = $urandom;
    endcase
    lo = $urandom;
    case ($urandom_range(0, 3))
      0: hi = lo + $urandom_range(0, 20);
      1: hi = $urandom;
      2: hi = lo - $urandom_range(1, 50);
      default: hi = lo + ($urandom >> $urandom_range(0, 31));
    endcase
    if (op == OpRange && $signed(hi) < $signed(lo) && $urandom_range(0, 2) != 0) begin
      {lo, hi} = {hi, lo};
    end
    send_request(op, bound, lo, hi);
  endtask

  initial begin : receiver
    int unsigned gap;
    bit [32:0] got;
    string msg;
    forever begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(negedge clk_i); while (!rsp_if.valid);
      got = rsp_if.data;
      @(posedge clk_i);
      msg = sb.check_result(got);
      words_checked++;
      if (msg != "") report(msg);
    end
  end

  initial begin : stimulus
    logic [63:0] seeds[4];
    logic [63:0] streams[4];
    sb.init();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(OpRaw, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OpBound, 32'd0, '0, '0);
    send_request(OpBound, 32'd1, '0, '0);
    send_request(OpBound, 32'hffff_ffff, '0, '0);
    send_request(OpBound, 32'h8000_0001, '0, '0);
    send_request(OpBound, 32'h8000_0000, '0, '0);
    send_request(OpBound, 32'd3, '0, '0);
    send_request(OpRange, 32'h8000_0000, 32'h7fff_ffff, '0);
    send_request(OpRange, '0, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OpRange, '0, 32'h7fff_ffff, 32'h8000_0000);
    send_request(OpRange, '0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(OpRange, '0, 32'h8000_0000, 32'h8000_0000);
    send_request(OpRange, '0, 32'hffff_fff6, 32'd10);
    send_request(OpRange, '0, 32'd5, 32'd4);
    send_request(OpSeed, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OpRaw, '0, '0, '0);
    end_burst();
    wait_drained();

    seeds = '{64'hffff_ffff_ffff_ffff, 64'h0, {$urandom, $urandom}, {$urandom, $urandom}};
    streams = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0,
                {$urandom, $urandom}};
    for (int ph = 0; ph < 4; ph++) begin
      set_registers(seeds[ph], streams[ph]);
      send_request(OpSeed, $urandom, $urandom, $urandom);
      for (int n = 0; n < 295; n++) begin
        random_request();
        if (ph == 1 && n == 150) begin
          end_burst();
          while (sb.expected_words.size() != 0) @(posedge clk_i);
        end
      end
      end_burst();
      wait_drained();
    end

    $display("covered %0d raw, %0d bounded, %0d range (%0d inverted), %0d reseed requests",
             op_count[OpRaw], op_count[OpBound], op_count[OpRange], range_errors,
             op_count[OpSeed]);
    $display("checked %0d result words over five register settings", words_checked);
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
